// ===== rtl/wqt_pkg.sv =====
// Package: shared constants, command and status types for the wait queue.
package wqt_pkg;

    localparam int ID_W    = 16;
    localparam int TICK_W  = 8;
    localparam int DATA_W  = 64;
    localparam int ENTRY_W = ID_W + TICK_W;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int BEAT_W  = ID_W + 2 * DATA_W;

    localparam logic [TICK_W-1:0] RESET_TIMEOUT = 8'd5;

    localparam logic [OP_W-1:0] OP_WAIT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [KIND_W-1:0] KIND_OK       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TIMEDOUT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd3;

    typedef enum logic [2:0] {
        SRC_REJECT = 3'd0,
        SRC_EMPTY  = 3'd1,
        SRC_SENDER = 3'd2,
        SRC_WAITER = 3'd3,
        SRC_PEND   = 3'd4
    } t_src;

    typedef struct packed {
        logic in_load;
        logic push;
        logic pop;
        logic rd_en;
        logic rd_walk;
        logic wb;
        logic walk_init;
        logic walk_adv;
        logic pend_set;
        logic pend_clr;
        logic commit;
        logic out_load;
        t_src out_src;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            out_free;
        logic            expire;
        logic            walk_last;
        logic            pend_valid;
    } t_stat;

endpackage

// ===== rtl/wqt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wqt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wqt_ctrl.sv =====
// Controller: sequences requests, sends and the tick walk over the queue.
module wqt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wqt_pkg::t_stat i_stat,
    output wqt_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DISP  = 6'b000010,
        ST_SEND2 = 6'b000100,
        ST_TRD   = 6'b001000,
        ST_TPROC = 6'b010000,
        ST_TEND  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (i_stat.op)
                    wqt_pkg::OP_WAIT: begin
                        if (!i_stat.full) begin
                            o_cmd.push = 1'b1;
                            n_state    = ST_IDLE;
                        end else if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_src  = wqt_pkg::SRC_REJECT;
                            o_cmd.out_last = 1'b1;
                            n_state        = ST_IDLE;
                        end
                    end
                    wqt_pkg::OP_SEND: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.out_src  = wqt_pkg::SRC_EMPTY;
                                o_cmd.out_last = 1'b1;
                                n_state        = ST_IDLE;
                            end else begin
                                o_cmd.out_src = wqt_pkg::SRC_SENDER;
                                o_cmd.rd_en   = 1'b1;
                                n_state       = ST_SEND2;
                            end
                        end
                    end
                    wqt_pkg::OP_TICK: begin
                        if (i_stat.empty) begin
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = ST_TRD;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SEND2: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = wqt_pkg::SRC_WAITER;
                    o_cmd.out_last = 1'b1;
                    o_cmd.pop      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_TRD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_walk = 1'b1;
                n_state       = ST_TPROC;
            end
            ST_TPROC: begin
                if (!(i_stat.expire && i_stat.pend_valid && !i_stat.out_free)) begin
                    if (i_stat.expire) begin
                        // hold newest expiry back so the final one can carry tlast
                        o_cmd.pend_set = 1'b1;
                        if (i_stat.pend_valid) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_src  = wqt_pkg::SRC_PEND;
                        end
                    end else begin
                        o_cmd.wb = 1'b1;
                    end
                    o_cmd.walk_adv = 1'b1;
                    n_state        = i_stat.walk_last ? ST_TEND : ST_TRD;
                end
            end
            ST_TEND: begin
                if (!i_stat.pend_valid) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = wqt_pkg::SRC_PEND;
                    o_cmd.out_last = 1'b1;
                    o_cmd.pend_clr = 1'b1;
                    o_cmd.commit   = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/wqt_dp.sv =====
// Datapath: request registers, ring pointers, entry RAM and output register.
module wqt_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wqt_pkg::t_cmd                 i_cmd,
    output wqt_pkg::t_stat                o_stat,
    input  logic [wqt_pkg::OP_W-1:0]      i_op,
    input  logic [wqt_pkg::ID_W-1:0]      i_client,
    input  logic [wqt_pkg::DATA_W-1:0]    i_x,
    input  logic [wqt_pkg::DATA_W-1:0]    i_y,
    input  logic                          i_cfg_we,
    input  logic [wqt_pkg::TICK_W-1:0]    i_cfg_wdata,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [wqt_pkg::ID_W-1:0]      o_out_client,
    output logic [wqt_pkg::KIND_W-1:0]    o_out_kind,
    output logic [wqt_pkg::DATA_W-1:0]    o_out_x,
    output logic [wqt_pkg::DATA_W-1:0]    o_out_y,
    output logic                          o_out_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(base) + (CW + 1)'(off);
        if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
            s = s - (CW + 1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [wqt_pkg::OP_W-1:0]    r_op;
    logic [wqt_pkg::ID_W-1:0]    r_client;
    logic [wqt_pkg::DATA_W-1:0]  r_x;
    logic [wqt_pkg::DATA_W-1:0]  r_y;
    logic [wqt_pkg::TICK_W-1:0]  r_timeout;
    logic [AW-1:0]               r_head;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_idx;
    logic [CW-1:0]               r_keep;
    logic                        r_pend_valid;
    logic [wqt_pkg::ID_W-1:0]    r_pend_id;
    logic                        r_out_valid;
    logic [wqt_pkg::ID_W-1:0]    r_out_client;
    logic [wqt_pkg::KIND_W-1:0]  r_out_kind;
    logic [wqt_pkg::DATA_W-1:0]  r_out_x;
    logic [wqt_pkg::DATA_W-1:0]  r_out_y;
    logic                        r_out_last;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [wqt_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [wqt_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [wqt_pkg::ID_W-1:0]     rd_id;
    logic [wqt_pkg::TICK_W-1:0]   rd_tick;
    logic [wqt_pkg::TICK_W-1:0]   init_tick;

    assign rd_id     = ram_rdata[wqt_pkg::ENTRY_W-1:wqt_pkg::TICK_W];
    assign rd_tick   = ram_rdata[wqt_pkg::TICK_W-1:0];
    assign init_tick = (r_timeout == '0) ? wqt_pkg::TICK_W'(1) : r_timeout;

    assign ram_we    = i_cmd.push | i_cmd.wb;
    assign ram_waddr = i_cmd.push ? wrap(r_head, r_count) : wrap(r_head, r_keep);
    assign ram_wdata = i_cmd.push ? {r_client, init_tick}
                                  : {rd_id, rd_tick - wqt_pkg::TICK_W'(1)};
    assign ram_raddr = i_cmd.rd_walk ? wrap(r_head, r_idx) : r_head;

    wqt_ram #(
        .WIDTH (wqt_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_op     <= i_op;
            r_client <= i_client;
            r_x      <= i_x;
            r_y      <= i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= wqt_pkg::RESET_TIMEOUT;
            r_head       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                r_head  <= wrap(r_head, CW'(1));
            end else if (i_cmd.commit) begin
                r_count <= r_keep;
            end
            if (i_cmd.walk_init || i_cmd.pend_clr) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.pend_set) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_idx  <= '0;
            r_keep <= '0;
        end else begin
            if (i_cmd.walk_adv) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.wb) begin
                r_keep <= r_keep + CW'(1);
            end
        end
        if (i_cmd.pend_set) begin
            r_pend_id <= rd_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_last <= i_cmd.out_last;
            unique case (i_cmd.out_src)
                wqt_pkg::SRC_REJECT: begin
                    r_out_client <= r_client;
                    r_out_kind   <= wqt_pkg::KIND_FULL;
                    r_out_x      <= '0;
                    r_out_y      <= '0;
                end
                wqt_pkg::SRC_EMPTY: begin
                    r_out_client <= r_client;
                    r_out_kind   <= wqt_pkg::KIND_EMPTY;
                    r_out_x      <= '0;
                    r_out_y      <= '0;
                end
                wqt_pkg::SRC_SENDER: begin
                    r_out_client <= r_client;
                    r_out_kind   <= wqt_pkg::KIND_OK;
                    r_out_x      <= r_x;
                    r_out_y      <= r_y;
                end
                wqt_pkg::SRC_WAITER: begin
                    r_out_client <= rd_id;
                    r_out_kind   <= wqt_pkg::KIND_OK;
                    r_out_x      <= r_x;
                    r_out_y      <= r_y;
                end
                wqt_pkg::SRC_PEND: begin
                    r_out_client <= r_pend_id;
                    r_out_kind   <= wqt_pkg::KIND_TIMEDOUT;
                    r_out_x      <= '0;
                    r_out_y      <= '0;
                end
                default: begin
                    r_out_client <= '0;
                    r_out_kind   <= wqt_pkg::KIND_OK;
                    r_out_x      <= '0;
                    r_out_y      <= '0;
                end
            endcase
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.full       = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.out_free   = ~r_out_valid | i_out_ready;
    assign o_stat.expire     = (rd_tick <= wqt_pkg::TICK_W'(1));
    assign o_stat.walk_last  = ((CW + 1)'(r_idx) + (CW + 1)'(1)) == (CW + 1)'(r_count);
    assign o_stat.pend_valid = r_pend_valid;

    assign o_out_valid  = r_out_valid;
    assign o_out_client = r_out_client;
    assign o_out_kind   = r_out_kind;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_out_last   = r_out_last;

endmodule

// ===== rtl/wait_queue_with_timeouts.sv =====
// Top level: wait queue of client ids with tick timeouts.
//
// Input stream (i_s_*): one beat per request. tuser carries the opcode
// (wait, send, tick); tdata carries client id and the two data words.
// Output stream (o_m_*): reply beats; tlast marks the final reply of a request.
// Config: i_cfg_we/i_cfg_wdata write the timeout in ticks (reset value 5).
// Entries live in a ring buffer RAM, one entry read or written per cycle.
// Wait: queues the client, no reply (one reject reply when full).
// Send: sender OK then oldest waiter OK (one error reply when empty).
// Tick: each queued entry costs a RAM read; entries that stay get a write-back,
// expired ones leave with a timed-out reply in queue order.
// One request is in flight at a time; o_s_tready is high when idle.
// The output register lets the last reply wait while the next beat is taken;
// a stalled receiver stalls the walk at the next reply.
// Synchronous active-low reset empties the queue and restores the timeout;
// no clearing pass is needed.
module wait_queue_with_timeouts #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [wqt_pkg::BEAT_W-1:0]    i_s_tdata,  // client_id, data_x, data_y
    input  logic [wqt_pkg::OP_W-1:0]      i_s_tuser,  // opcode
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [wqt_pkg::BEAT_W-1:0]    o_m_tdata,  // reply_client, reply_x, reply_y
    output logic [wqt_pkg::KIND_W-1:0]    o_m_tuser,  // reply_kind
    output logic                          o_m_tlast,
    input  logic                          i_cfg_we,
    input  logic [wqt_pkg::TICK_W-1:0]    i_cfg_wdata
);

    localparam int XL = wqt_pkg::ID_W;
    localparam int YL = wqt_pkg::ID_W + wqt_pkg::DATA_W;

    wqt_pkg::t_cmd  cmd;
    wqt_pkg::t_stat stat;

    logic [wqt_pkg::ID_W-1:0]   out_client;
    logic [wqt_pkg::DATA_W-1:0] out_x;
    logic [wqt_pkg::DATA_W-1:0] out_y;

    wqt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wqt_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_s_tuser),
        .i_client     (i_s_tdata[XL-1:0]),
        .i_x          (i_s_tdata[YL-1:XL]),
        .i_y          (i_s_tdata[wqt_pkg::BEAT_W-1:YL]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_out_client (out_client),
        .o_out_kind   (o_m_tuser),
        .o_out_x      (out_x),
        .o_out_y      (out_y),
        .o_out_last   (o_m_tlast)
    );

    assign o_m_tdata = {out_y, out_x, out_client};

    // a reply is only loaded when the output register is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("reply loaded over an untaken beat");

    // RAM has one write port: append and compaction write never collide
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.push && cmd.wb))
        else $error("two RAM writes in one cycle");

    // a held timeout reply only exists while a tick walk is in progress
    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pend_valid |-> !o_s_tready)
        else $error("pending timeout reply while idle");

    // an append always leaves the queue non-empty
    a_count_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> !stat.empty)
        else $error("queue empty right after an append");

endmodule
